FILE: rtl/tracking_pose_transform_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the pose transform block
// ---------------------------------------------------------------------------
`ifndef TRACKING_POSE_TRANSFORM_ASSERT_SVH
`define TRACKING_POSE_TRANSFORM_ASSERT_SVH

// check that an implication holds at every edge out of reset
`define TPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property including during reset
`define TPT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tpt_pkg.sv
// ---------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants for the pose transform pipeline.
// ---------------------------------------------------------------------------
package tpt_pkg;

    localparam int unsigned AtanLen = 24;
    localparam int unsigned AngW    = 26;   // degrees, 16 fraction bits
    localparam int unsigned VecW    = 36;   // CORDIC vector width, room for the gain
    localparam logic signed [AngW-1:0] Deg180 = 26'sd11796480;
    localparam logic signed [14:0] RotLimit = 15'sd11520;

    localparam logic [2:0] RegOffX  = 3'd0;
    localparam logic [2:0] RegOffY  = 3'd1;
    localparam logic [2:0] RegOffZ  = 3'd2;
    localparam logic [2:0] RegSclX  = 3'd3;
    localparam logic [2:0] RegSclY  = 3'd4;
    localparam logic [2:0] RegSclZ  = 3'd5;
    localparam logic [2:0] RegFlip  = 3'd6;

    // one CORDIC cell's state
    typedef struct packed {
        logic                   vld;
        logic                   act;   // CORDIC result used
        logic signed [VecW-1:0] c;
        logic signed [VecW-1:0] s;
        logic signed [AngW-1:0] ang;
        logic signed [14:0]     rot;   // pass-through yaw
        logic                   rvld;
    } t_cell;

    function automatic logic signed [AngW-1:0] atan_deg(input logic [4:0] i);
        case (i)
            5'd0:  atan_deg = 26'sd2949120;
            5'd1:  atan_deg = 26'sd1740967;
            5'd2:  atan_deg = 26'sd919879;
            5'd3:  atan_deg = 26'sd466945;
            5'd4:  atan_deg = 26'sd234379;
            5'd5:  atan_deg = 26'sd117304;
            5'd6:  atan_deg = 26'sd58666;
            5'd7:  atan_deg = 26'sd29335;
            5'd8:  atan_deg = 26'sd14668;
            5'd9:  atan_deg = 26'sd7334;
            5'd10: atan_deg = 26'sd3667;
            5'd11: atan_deg = 26'sd1833;
            5'd12: atan_deg = 26'sd917;
            5'd13: atan_deg = 26'sd458;
            5'd14: atan_deg = 26'sd229;
            5'd15: atan_deg = 26'sd115;
            5'd16: atan_deg = 26'sd57;
            5'd17: atan_deg = 26'sd29;
            5'd18: atan_deg = 26'sd14;
            5'd19: atan_deg = 26'sd7;
            5'd20: atan_deg = 26'sd4;
            5'd21: atan_deg = 26'sd2;
            5'd22: atan_deg = 26'sd1;
            default: atan_deg = 26'sd0;
        endcase
    endfunction

endpackage

FILE: rtl/tpt_cordic_cell.sv
// ---------------------------------------------------------------------------
// tpt_cordic_cell
// One vectoring CORDIC micro-rotation, registered, with stall hold.
// ---------------------------------------------------------------------------
module tpt_cordic_cell #(
    parameter int unsigned STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tpt_pkg::t_cell  i_cell,
    output tpt_pkg::t_cell  o_cell
);
    import tpt_pkg::*;

    t_cell r_cell;
    t_cell n_cell;

    // rotate toward zero s, arithmetic shifts floor
    always_comb begin
        n_cell = i_cell;
        if (i_cell.act) begin
            if (!i_cell.s[VecW-1]) begin
                n_cell.c   = i_cell.c + (i_cell.s >>> STEP);
                n_cell.s   = i_cell.s - (i_cell.c >>> STEP);
                n_cell.ang = i_cell.ang + atan_deg(5'(STEP));
            end else begin
                n_cell.c   = i_cell.c - (i_cell.s >>> STEP);
                n_cell.s   = i_cell.s + (i_cell.c >>> STEP);
                n_cell.ang = i_cell.ang - atan_deg(5'(STEP));
            end
        end
    end

    // advance when the chain moves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell.vld <= n_cell.vld;
        end
        if (i_en) begin
            r_cell.act  <= n_cell.act;
            r_cell.c    <= n_cell.c;
            r_cell.s    <= n_cell.s;
            r_cell.ang  <= n_cell.ang;
            r_cell.rot  <= n_cell.rot;
            r_cell.rvld <= n_cell.rvld;
        end
    end

    assign o_cell = r_cell;
endmodule

FILE: rtl/tracking_pose_transform.sv
// Throughput: one pose per cycle; the chain of CORDIC cells and the
// position pipeline advance together whenever the output is not stalled.
// Reset (synchronous, active low) clears the valid bit of each yaw stage and o_valid,
// and sets the registers to offset 0, scale 1.0 and no flips.
// ---------------------------------------------------------------------------
// tracking_pose_transform
// Affine position transform and quaternion yaw by a CORDIC cell chain.
// ---------------------------------------------------------------------------
module tracking_pose_transform #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_tracker_id,
    input  logic               i_has_position,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_has_quaternion,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic               i_has_euler,
    input  logic signed [15:0] i_euler_yaw,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_tracker_id_out,
    output logic               o_position_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic               o_rotation_valid,
    output logic signed [14:0] o_rotation_deg
);
    import tpt_pkg::*;
    `include "tracking_pose_transform_assert.svh"

    localparam int unsigned Steps = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
    localparam int unsigned Lat   = Steps + 2;  // stages before output reg

    logic signed [31:0] r_off [3];
    logic signed [31:0] r_scl [3];
    logic [2:0]         r_flip;

    logic en;
    assign en          = !(o_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_off[k] <= '0;
                r_scl[k] <= 32'sd65536;
            end
            r_flip <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                RegOffX: r_off[0] <= i_cfg_data;
                RegOffY: r_off[1] <= i_cfg_data;
                RegOffZ: r_off[2] <= i_cfg_data;
                RegSclX: r_scl[0] <= i_cfg_data;
                RegSclY: r_scl[1] <= i_cfg_data;
                RegSclZ: r_scl[2] <= i_cfg_data;
                RegFlip: r_flip   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ---------------- yaw front end: products (stage 1) ----------------
    logic               r1_vld, r1_hq, r1_he;
    logic signed [31:0] r1_wz, r1_xy, r1_yy, r1_zz;
    logic signed [15:0] r1_eul;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (en)  r1_vld <= i_valid;
        if (en) begin
            r1_hq  <= i_has_quaternion;
            r1_he  <= i_has_euler;
            r1_wz  <= i_quat_w * i_quat_z;
            r1_xy  <= i_quat_x * i_quat_y;
            r1_yy  <= i_quat_y * i_quat_y;
            r1_zz  <= i_quat_z * i_quat_z;
            r1_eul <= i_euler_yaw;
        end
    end

    // stage 2: form s, c, pre-rotate into the right half plane
    logic signed [VecW-1:0] s0, c0;
    t_cell n_c0, r_c0;
    always_comb begin
        s0 = (VecW'(r1_wz) + VecW'(r1_xy)) <<< 1;
        c0 = (VecW'(34'sd1) <<< 28) - ((VecW'(r1_yy) + VecW'(r1_zz)) <<< 1);
        n_c0      = '0;
        n_c0.vld  = r1_vld;
        n_c0.rvld = r1_hq || r1_he;
        n_c0.act  = r1_hq && !(s0 == '0 && c0 == '0);
        n_c0.c    = c0;
        n_c0.s    = s0;
        if (c0[VecW-1]) begin
            n_c0.ang = s0[VecW-1] ? -Deg180 : Deg180;
            n_c0.c   = -c0;
            n_c0.s   = -s0;
        end
        if (r1_hq)
            n_c0.rot = '0;
        else if (r1_eul > 16'sd11520)
            n_c0.rot = RotLimit;
        else if (r1_eul < -16'sd11520)
            n_c0.rot = -RotLimit;
        else
            n_c0.rot = r1_eul[14:0];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c0.vld <= 1'b0;
        else if (en)  r_c0.vld <= n_c0.vld;
        if (en) begin
            r_c0.act  <= n_c0.act;
            r_c0.c    <= n_c0.c;
            r_c0.s    <= n_c0.s;
            r_c0.ang  <= n_c0.ang;
            r_c0.rot  <= n_c0.rot;
            r_c0.rvld <= n_c0.rvld;
        end
    end

    // chain of CORDIC cells
    t_cell chain [Steps+1];
    assign chain[0] = r_c0;
    for (genvar g = 0; g < Steps; g++) begin : g_cell
        tpt_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    // round to Q9.6 and clamp
    t_cell tail;
    logic signed [AngW-1:0] ang_mag, ang_rnd;
    logic signed [AngW-1:0] rot_w;
    logic signed [14:0]     rot_fin;
    assign tail = chain[Steps];
    always_comb begin
        ang_mag = tail.ang[AngW-1] ? -tail.ang : tail.ang;
        ang_rnd = (ang_mag + 26'sd512) >>> 10;
        rot_w   = tail.ang[AngW-1] ? -ang_rnd : ang_rnd;
        if (!tail.act)               rot_fin = tail.rot;
        else if (rot_w > 26'sd11520) rot_fin = RotLimit;
        else if (rot_w < -26'sd11520) rot_fin = -RotLimit;
        else                         rot_fin = rot_w[14:0];
    end

    // ---------------- position path ----------------
    // stage A: sums and magnitudes
    logic               ra_hp;
    logic [32:0]        ra_ms [3];
    logic [31:0]        ra_mc [3];
    logic [2:0]         ra_neg;
    // stage B: product
    logic               rb_hp;
    logic [64:0]        rb_p  [3];
    logic [2:0]         rb_neg;
    // stage C: round and saturate
    logic               rc_hp;
    logic signed [31:0] rc_o  [3];

    always_ff @(posedge i_clk) begin
        logic signed [32:0] sm;
        logic [48:0]        mag;
        if (en) begin
            ra_hp <= i_has_position;
            for (int k = 0; k < 3; k++) begin
                sm = (k == 0) ? 33'(i_pos_x) : (k == 1) ? 33'(i_pos_y) : 33'(i_pos_z);
                sm = sm + 33'(r_off[k]);
                ra_ms[k]  <= sm[32] ? 33'(-sm) : 33'(sm);
                ra_mc[k]  <= r_scl[k][31] ? 32'(-r_scl[k]) : 32'(r_scl[k]);
                ra_neg[k] <= sm[32] ^ r_scl[k][31] ^ r_flip[k];
            end
            rb_hp  <= ra_hp;
            rb_neg <= ra_neg;
            for (int k = 0; k < 3; k++)
                rb_p[k] <= 65'(ra_ms[k]) * 65'(ra_mc[k]);
            rc_hp <= rb_hp;
            for (int k = 0; k < 3; k++) begin
                mag = 49'((rb_p[k] + 65'h8000) >> 16);
                if (!rb_hp || mag == '0)
                    rc_o[k] <= '0;
                else if (rb_neg[k])
                    rc_o[k] <= (mag >= 49'h80000000) ? 32'h80000000 : 32'(-mag);
                else
                    rc_o[k] <= (mag > 49'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
            end
        end
    end

    // delay line for position result and id to meet the yaw chain
    localparam int unsigned PosDly = Lat - 4;   // = Steps - 2
    logic [15:0]        r_id  [Lat];
    logic               r_hp  [PosDly+1];
    logic signed [31:0] r_px  [PosDly+1];
    logic signed [31:0] r_py  [PosDly+1];
    logic signed [31:0] r_pz  [PosDly+1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_id[0] <= i_tracker_id;
            for (int k = 1; k < Lat; k++) r_id[k] <= r_id[k-1];
            r_hp[0] <= rc_hp;
            r_px[0] <= rc_o[0];
            r_py[0] <= rc_o[1];
            r_pz[0] <= rc_o[2];
            for (int k = 1; k <= PosDly; k++) begin
                r_hp[k] <= r_hp[k-1];
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
                r_pz[k] <= r_pz[k-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en)  o_valid <= tail.vld;
        if (en) begin
            o_tracker_id_out <= r_id[Lat-1];
            o_position_valid <= r_hp[PosDly];
            o_out_x          <= r_px[PosDly];
            o_out_y          <= r_py[PosDly];
            o_out_z          <= r_pz[PosDly];
            o_rotation_valid <= tail.rvld;
            o_rotation_deg   <= tail.rvld ? rot_fin : 15'sd0;
        end
    end

    `TPT_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_out_x)), "result changed while stalled")
    `TPT_ASSERT(a_rot_rng, i_clk, i_rst_n, o_valid |-> (o_rotation_deg <= 15'sd11520 && o_rotation_deg >= -15'sd11520), "yaw out of range")
    `TPT_ASSERT(a_pos_zero, i_clk, i_rst_n, (o_valid && !o_position_valid) |-> (o_out_x == 0 && o_out_y == 0 && o_out_z == 0), "position not cleared")
endmodule
